### rtl/core/plir_pkg.sv
// ----------------------------------------------------------------------------
// plir_pkg
// shared types and constants for the positional list with id removal
// ----------------------------------------------------------------------------
package plir_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int HANDLE_W      = 32;
    localparam int ID_W          = 32;
    localparam int POS_W         = 8;
    localparam int OPCODE_W      = 2;
    localparam int CNT_OUT_W     = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_PULL_POS = 2'd1,
        OP_PULL_ID  = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic                en;
        op_t                 op;
        logic                pos_ok;
        logic [HANDLE_W-1:0] handle;
        logic [ID_W-1:0]     id;
    } chain_cmd_t;

endpackage

### rtl/core/plir_cell.sv
// ----------------------------------------------------------------------------
// plir_cell
// one list slot: holds a handle and an id, shifts toward either neighbor
// ----------------------------------------------------------------------------
module plir_cell import plir_pkg::*; #(
    parameter int IDX   = 0,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic                aclk,
    input  chain_cmd_t          cmd,
    input  logic [IDX_W-1:0]    pos,
    input  logic [CNT_W-1:0]    count,
    input  logic [HANDLE_W-1:0] left_handle,
    input  logic [ID_W-1:0]     left_id,
    input  logic [HANDLE_W-1:0] right_handle,
    input  logic [ID_W-1:0]     right_id,
    input  logic                seen_in,
    input  logic [HANDLE_W-1:0] acc_in,
    output logic [HANDLE_W-1:0] handle_q,
    output logic [ID_W-1:0]     id_q,
    output logic                seen_out,
    output logic [HANDLE_W-1:0] acc_out
);

    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic                hit;
    logic                at_pos;
    logic                after_pos;
    logic                in_list;

    assign at_pos    = (IDX_W'(IDX) == pos);
    assign after_pos = (IDX_W'(IDX) > pos);
    assign in_list   = (CNT_W'(IDX) < count);

    always_comb begin
        hit = ((cmd.op == OP_PULL_POS) && cmd.pos_ok && at_pos) ||
              ((cmd.op == OP_PULL_ID) && in_list && (id_reg == cmd.id));
    end

    assign seen_out = seen_in | hit;
    assign acc_out  = acc_in | ((hit && !seen_in) ? handle_reg : '0);

    always_comb begin
        handle_next = handle_reg;
        id_next     = id_reg;
        if (cmd.en) begin
            unique case (cmd.op)
                OP_INSERT: begin
                    if (cmd.pos_ok && after_pos) begin
                        handle_next = left_handle;
                        id_next     = left_id;
                    end else if (cmd.pos_ok && at_pos) begin
                        handle_next = cmd.handle;
                        id_next     = cmd.id;
                    end
                end
                OP_PULL_POS, OP_PULL_ID: begin
                    if (seen_out) begin
                        handle_next = right_handle;
                        id_next     = right_id;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        handle_reg <= handle_next;
        id_reg     <= id_next;
    end

    assign handle_q = handle_reg;
    assign id_q     = id_reg;

endmodule

### rtl/core/plir_chain.sv
// ----------------------------------------------------------------------------
// plir_chain
// row of list cells with first-match and handle collection chains
// ----------------------------------------------------------------------------
module plir_chain import plir_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic                aclk,
    input  chain_cmd_t          cmd,
    input  logic [IDX_W-1:0]    pos,
    input  logic [CNT_W-1:0]    count,
    output logic                found,
    output logic [HANDLE_W-1:0] handle_out
);

    logic [HANDLE_W-1:0] handle_q [DEPTH];
    logic [ID_W-1:0]     id_q     [DEPTH];
    logic [DEPTH:0]      seen;
    logic [HANDLE_W-1:0] acc      [DEPTH+1];

    assign seen[0] = 1'b0;
    assign acc[0]  = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [HANDLE_W-1:0] left_handle, right_handle;
        logic [ID_W-1:0]     left_id, right_id;

        if (i == 0) begin : g_first
            assign left_handle = '0;
            assign left_id     = '0;
        end else begin : g_mid_l
            assign left_handle = handle_q[i-1];
            assign left_id     = id_q[i-1];
        end

        if (i == DEPTH-1) begin : g_last
            assign right_handle = '0;
            assign right_id     = '0;
        end else begin : g_mid_r
            assign right_handle = handle_q[i+1];
            assign right_id     = id_q[i+1];
        end

        plir_cell #(
            .IDX   (i),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk         (aclk),
            .cmd          (cmd),
            .pos          (pos),
            .count        (count),
            .left_handle  (left_handle),
            .left_id      (left_id),
            .right_handle (right_handle),
            .right_id     (right_id),
            .seen_in      (seen[i]),
            .acc_in       (acc[i]),
            .handle_q     (handle_q[i]),
            .id_q         (id_q[i]),
            .seen_out     (seen[i+1]),
            .acc_out      (acc[i+1])
        );
    end

    assign found      = seen[DEPTH];
    assign handle_out = acc[DEPTH];

endmodule

### rtl/core/positional_list_with_id_removal.sv
// ----------------------------------------------------------------------------
// positional_list_with_id_removal
// ordered list with insert at position, pull at position and pull by id
// ----------------------------------------------------------------------------
// Each entry lives in one cell of a row of DEPTH cells; an insert shifts the
// tail one cell down, a pull closes the gap by shifting the tail one cell up,
// and a pull by id finds the first matching cell through a match chain that
// runs along the row. A new item is not taken before the last is done: in
// ST_IDLE the transfer registers the command and resolves the position
// against the entry count, and ST_EXEC runs the match chain, updates all
// cells at once and loads the result register. ST_EXEC waits while an earlier
// result is still held on the result channel. Entry storage has no reset; only
// the entry count, the state and the result valid flag are cleared.
// ----------------------------------------------------------------------------
module positional_list_with_id_removal import plir_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OPCODE_W-1:0]  s_opcode,
    input  logic [POS_W-1:0]     s_position,
    input  logic [HANDLE_W-1:0]  s_entry_handle,
    input  logic [ID_W-1:0]      s_entry_id,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_ok,
    output logic [HANDLE_W-1:0]  m_handle_out,
    output logic [CNT_OUT_W-1:0] m_entry_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    op_t                 op_reg, op_next;
    logic                pos_ok_reg, pos_ok_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic                m_valid_reg, m_valid_next;
    logic                ok_reg, ok_next;
    logic [HANDLE_W-1:0] hout_reg, hout_next;

    logic [PW-1:0]       pos_ext, cnt_ext, adj;
    logic                ins_ok, pull_ok;
    logic                exec_go;
    logic                found;
    logic [HANDLE_W-1:0] chain_handle;
    chain_cmd_t          cmd;

    // position resolution against the current count
    always_comb begin
        pos_ext = {{(PW-POS_W){s_position[POS_W-1]}}, s_position};
        cnt_ext = PW'(count_reg);
        if (s_position[POS_W-1]) begin
            adj = pos_ext + cnt_ext + ((op_t'(s_opcode) == OP_INSERT) ? PW'(1) : PW'(0));
        end else begin
            adj = pos_ext;
        end
        ins_ok  = !adj[PW-1] && (adj <= cnt_ext) && (count_reg < CNT_W'(DEPTH));
        pull_ok = !adj[PW-1] && (adj < cnt_ext);
    end

    assign exec_go = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    always_comb begin
        cmd.en     = exec_go;
        cmd.op     = op_reg;
        cmd.pos_ok = pos_ok_reg;
        cmd.handle = handle_reg;
        cmd.id     = id_reg;
    end

    plir_chain #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_chain (
        .aclk       (aclk),
        .cmd        (cmd),
        .pos        (pos_reg),
        .count      (count_reg),
        .found      (found),
        .handle_out (chain_handle)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        pos_ok_next  = pos_ok_reg;
        pos_next     = pos_reg;
        handle_next  = handle_reg;
        id_next      = id_reg;
        m_valid_next = m_valid_reg;
        ok_next      = ok_reg;
        hout_next    = hout_reg;
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next     = op_t'(s_opcode);
                    pos_ok_next = (op_t'(s_opcode) == OP_INSERT) ? ins_ok : pull_ok;
                    pos_next    = adj[IDX_W-1:0];
                    handle_next = s_entry_handle;
                    id_next     = s_entry_id;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    m_valid_next = 1'b1;
                    hout_next    = chain_handle;
                    unique case (op_reg)
                        OP_INSERT: begin
                            ok_next = pos_ok_reg;
                            if (pos_ok_reg) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_PULL_POS, OP_PULL_ID: begin
                            ok_next = found;
                            if (found) begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        default: begin
                            ok_next = 1'b0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        pos_ok_reg <= pos_ok_next;
        pos_reg    <= pos_next;
        handle_reg <= handle_next;
        id_reg     <= id_next;
        ok_reg     <= ok_next;
        hout_reg   <= hout_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_ok          = ok_reg;
    assign m_handle_out  = hout_reg;
    assign m_entry_count = CNT_OUT_W'(count_reg);

endmodule

### rtl/core/plir_checker.sv
// ----------------------------------------------------------------------------
// plir_checker
// port-level checks on the positional list, bound to the top level
// ----------------------------------------------------------------------------
module plir_checker import plir_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_ok,
    input logic [HANDLE_W-1:0]  m_handle_out,
    input logic [CNT_OUT_W-1:0] m_entry_count
);

    // reset empties the result slot
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a failed operation returns no handle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_handle_out == '0))
        else $error("handle on failed operation");

    // one item in flight: no transfer in the cycle after a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken on consecutive cycles");

    // a held result keeps its values
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_ok) &&
                                   $stable(m_handle_out) && $stable(m_entry_count)))
        else $error("held result changed");

endmodule

bind positional_list_with_id_removal plir_checker u_plir_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_ok          (m_ok),
    .m_handle_out  (m_handle_out),
    .m_entry_count (m_entry_count)
);

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the positional list with id removal
// ----------------------------------------------------------------------------
// A directed sequence covers empty and out-of-range operations, the unused
// opcode, duplicate ids and extreme field values. Random grow, shrink and
// mixed phases then fill and drain the list, so the full-list case is
// reached. A scoreboard keeps its own copy of the list, predicts every
// result when a command transfer completes, and compares the result
// transfers in order. Both channels stall at random outside a calm stretch.
// ----------------------------------------------------------------------------
module testbench;
    import plir_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEFAULT;

    typedef struct {
        logic                 ok;
        logic [HANDLE_W-1:0]  handle;
        logic [CNT_OUT_W-1:0] count;
    } list_result_t;

    class list_scoreboard;
        logic [HANDLE_W-1:0] handles[$];
        logic [ID_W-1:0]     ids[$];
        list_result_t        expected_results[$];
        int                  errors = 0;

        function int size();
            return handles.size();
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_command(op_t op, logic [POS_W-1:0] pos_raw,
                                   logic [HANDLE_W-1:0] h, logic [ID_W-1:0] id);
            list_result_t r;
            int           p;
            int           n;
            n = handles.size();
            p = int'($signed(pos_raw));
            r.ok = 1'b0;
            r.handle = '0;
            case (op)
                OP_INSERT: begin
                    if (p < 0) p += n + 1;
                    if (p >= 0 && p <= n && n < LIST_DEPTH) begin
                        handles.insert(p, h);
                        ids.insert(p, id);
                        r.ok = 1'b1;
                    end
                end
                OP_PULL_POS: begin
                    if (p < 0) p += n;
                    if (p >= 0 && p < n) begin
                        r.handle = handles[p];
                        handles.delete(p);
                        ids.delete(p);
                        r.ok = 1'b1;
                    end
                end
                OP_PULL_ID: begin
                    for (int i = 0; i < n; i++) begin
                        if (ids[i] == id) begin
                            r.handle = handles[i];
                            handles.delete(i);
                            ids.delete(i);
                            r.ok = 1'b1;
                            break;
                        end
                    end
                end
                default: ;
            endcase
            r.count = CNT_OUT_W'(handles.size());
            expected_results.push_back(r);
        endfunction

        function void check_result(logic ok, logic [HANDLE_W-1:0] h,
                                   logic [CNT_OUT_W-1:0] cnt);
            list_result_t e;
            if (expected_results.size() == 0) begin
                $error("result transfer with no pending expectation");
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (ok !== e.ok) begin
                $error("m_ok: expected %0d, got %0d", e.ok, ok);
                errors++;
            end
            if (h !== e.handle) begin
                $error("m_handle_out: expected %08h, got %08h", e.handle, h);
                errors++;
            end
            if (cnt !== e.count) begin
                $error("m_entry_count: expected %0d, got %0d", e.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [OPCODE_W-1:0]  s_opcode = OP_NONE;
    logic [POS_W-1:0]     s_position = '0;
    logic [HANDLE_W-1:0]  s_entry_handle = '0;
    logic [ID_W-1:0]      s_entry_id = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_ok;
    logic [HANDLE_W-1:0]  m_handle_out;
    logic [CNT_OUT_W-1:0] m_entry_count;

    list_scoreboard sb = new();
    bit             calm = 1'b0;
    logic [ID_W-1:0] id_pool[12];

    positional_list_with_id_removal #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_position    (s_position),
        .s_entry_handle(s_entry_handle),
        .s_entry_id    (s_entry_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_handle_out  (m_handle_out),
        .m_entry_count (m_entry_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("[positional_list_with_id_removal] ERROR");
        $finish;
    end

    // command channel, one item per call
    task automatic send_command(op_t op, int pos, logic [HANDLE_W-1:0] h,
                                logic [ID_W-1:0] id);
        while (!calm && $urandom_range(0, 99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_position     <= POS_W'(pos);
        s_entry_handle <= h;
        s_entry_id     <= id;
        do @(posedge aclk); while (!s_ready);
        sb.note_command(op, POS_W'(pos), h, id);
    endtask

    // result channel
    initial begin
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_result(m_ok, m_handle_out, m_entry_count);
            m_ready <= calm || ($urandom_range(0, 99) >= 6);
        end
    end

    function automatic logic [ID_W-1:0] pick_id(bit searching);
        int roll;
        roll = $urandom_range(0, 99);
        if (searching && sb.size() > 0 && roll < 50)
            return sb.ids[$urandom_range(0, sb.size() - 1)];
        if (roll < 80) return id_pool[$urandom_range(0, 11)];
        return $urandom;
    endfunction

    function automatic int pick_position(op_t op);
        int n;
        n = sb.size();
        if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 2))
                0: return $urandom_range(0, 255);
                1: return (op == OP_INSERT) ? n + 1 : n;
                default: return (op == OP_INSERT) ? -(n + 2) : -(n + 1);
            endcase
        end
        if (op == OP_INSERT) return int'($urandom_range(0, 2 * n + 1)) - (n + 1);
        if (n == 0) return 0;
        return int'($urandom_range(0, 2 * n - 1)) - n;
    endfunction

    initial begin
        int   mode;
        int   phase_left;
        int   grow_pct;
        int   roll;
        op_t  op;

        foreach (id_pool[i]) id_pool[i] = $urandom;
        id_pool[0] = 32'h8000_0000;
        id_pool[1] = 32'h7fff_ffff;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list, bad positions, unused opcode
        send_command(OP_PULL_POS, 0, 32'h1111_1111, 32'h0);
        send_command(OP_PULL_ID, 0, 32'h0, 32'h0);
        send_command(OP_NONE, -1, 32'hffff_ffff, 32'hffff_ffff);
        send_command(OP_INSERT, 1, 32'h2222_2222, 32'h1);
        send_command(OP_INSERT, -2, 32'h3333_3333, 32'h2);
        // append, front, end, negative front, duplicate id
        send_command(OP_INSERT, -1, 32'hffff_ffff, 32'h8000_0000);
        send_command(OP_INSERT, 0, 32'h0000_0000, 32'h7fff_ffff);
        send_command(OP_INSERT, 2, 32'ha5a5_a5a5, 32'h0000_0000);
        send_command(OP_INSERT, -4, 32'h5a5a_5a5a, 32'hffff_ffff);
        send_command(OP_INSERT, 1, 32'h1234_5678, 32'h7fff_ffff);
        send_command(OP_INSERT, 127, 32'h4444_4444, 32'h3);
        send_command(OP_INSERT, -128, 32'h5555_5555, 32'h4);
        // first match among duplicates
        send_command(OP_PULL_ID, 0, 32'h0, 32'h7fff_ffff);
        send_command(OP_PULL_POS, -1, 32'h0, 32'h0);
        send_command(OP_PULL_POS, 3, 32'h0, 32'h0);
        send_command(OP_PULL_POS, -4, 32'h0, 32'h0);
        send_command(OP_PULL_POS, 127, 32'h0, 32'h0);
        send_command(OP_PULL_POS, -128, 32'h0, 32'h0);
        send_command(OP_PULL_POS, -3, 32'h0, 32'h0);
        send_command(OP_PULL_ID, 0, 32'h0, 32'h8000_0000);
        send_command(OP_PULL_ID, 64, 32'h0, 32'h7fff_ffff);
        send_command(OP_PULL_POS, 0, 32'h0, 32'h0);
        send_command(OP_PULL_POS, 0, 32'h0, 32'h0);

        mode = 0;
        phase_left = 200;
        for (int k = 0; k < 2000; k++) begin
            calm = (k >= 700 && k < 1000);
            if (phase_left == 0) begin
                mode = $urandom_range(0, 2);
                phase_left = $urandom_range(80, 250);
            end
            phase_left--;
            grow_pct = (mode == 0) ? 70 : (mode == 1) ? 25 : 45;
            roll = $urandom_range(0, 99);
            if (roll == 99) op = OP_NONE;
            else if (roll < grow_pct) op = OP_INSERT;
            else if (roll[0]) op = OP_PULL_POS;
            else op = OP_PULL_ID;
            send_command(op, pick_position(op), $urandom,
                         pick_id(op == OP_PULL_ID));
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0)
            $display("[positional_list_with_id_removal] OK");
        else
            $display("[positional_list_with_id_removal] ERROR");
        $finish;
    end

endmodule

### positional_list_with_id_removal.f
rtl/core/plir_pkg.sv
rtl/core/plir_cell.sv
rtl/core/plir_chain.sv
rtl/core/positional_list_with_id_removal.sv
rtl/core/plir_checker.sv
tb/sv/testbench.sv
